// ===== hdl/btss_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// btss_pkg
// Shared codes and types for the backtrack thread stack scheduler.
// ----------------------------------------------------------------------------
package btss_pkg;

  // operation codes carried on s_axis_tuser
  localparam logic [1:0] OP_SCHED = 2'd0;
  localparam logic [1:0] OP_ORDER = 2'd1;
  localparam logic [1:0] OP_NEXT  = 2'd2;
  localparam logic [1:0] OP_INIT  = 2'd3;

  localparam int unsigned OP_BITS     = 2;
  localparam int unsigned HANDLE_BITS = 16;

  // result flag positions in m_axis_tuser
  localparam int unsigned RES_NV_BIT  = 0;
  localparam int unsigned RES_HW_BIT  = 1;
  localparam int unsigned RES_OVF_BIT = 2;
  localparam int unsigned RES_BITS    = 3;

  // shift command broadcast to the stack cells
  typedef struct packed {
    logic ins;  // open a slot at the insert distance, shift deeper cells down
    logic pop;  // every cell takes its deeper neighbor
  } btss_cmd_t;

endpackage
`default_nettype wire

// ===== hdl/btss_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// btss_cell
// One stack entry. Cell 0 holds the top of stack; the distance from the top
// selects whether a cell keeps, loads the new handle or takes a neighbor.
// ----------------------------------------------------------------------------
module btss_cell
  import btss_pkg::*;
#(
  parameter int unsigned IDX = 0,
  parameter int unsigned DW  = 7,
  parameter int unsigned TW  = 16
) (
  input  wire logic          clk_i,
  input  wire btss_cmd_t     cmd_i,
  input  wire logic [DW-1:0] dist_i,
  input  wire logic [TW-1:0] new_i,
  input  wire logic [TW-1:0] upper_i,  // shallower neighbor
  input  wire logic [TW-1:0] lower_i,  // deeper neighbor
  output logic      [TW-1:0] data_o
);

  logic [TW-1:0] data_q, data_d;
  logic [DW-1:0] my_idx;

  assign my_idx = DW'(IDX);

  always_comb begin
    data_d = data_q;
    if (cmd_i.pop) begin
      data_d = lower_i;
    end else if (cmd_i.ins) begin
      if (my_idx == dist_i) begin
        data_d = new_i;
      end else if (my_idx > dist_i) begin
        data_d = upper_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

// ===== hdl/btss_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// btss_ctrl
// Active slot, stack count and insert index; decodes each operation into a
// shift command for the cell chain and the result flags.
// ----------------------------------------------------------------------------
module btss_ctrl
  import btss_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned CW    = 7,
  parameter int unsigned IW    = 7,
  parameter int unsigned TW    = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic [OP_BITS-1:0] op_i,
  input  wire logic [TW-1:0]      handle_i,
  input  wire logic [TW-1:0]      top_i,
  output btss_cmd_t               cmd_o,
  output logic      [CW-1:0]      dist_o,
  output logic      [TW-1:0]      next_thread_o,
  output logic                    next_valid_o,
  output logic                    has_work_o,
  output logic                    overflow_o
);

  logic          act_v_q, act_v_d;
  logic [TW-1:0] act_t_q, act_t_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] cnt_ext;
  logic          full;

  assign cnt_ext = IW'(cnt_q);
  assign full    = (cnt_q == CW'(DEPTH));

  always_comb begin
    act_v_d       = act_v_q;
    act_t_d       = act_t_q;
    cnt_d         = cnt_q;
    idx_d         = idx_q;
    cmd_o         = '0;
    dist_o        = '0;
    next_thread_o = '0;
    next_valid_o  = 1'b0;
    overflow_o    = 1'b0;
    if (accept_i) begin
      case (op_i)
        OP_SCHED, OP_ORDER: begin
          if (op_i == OP_SCHED || idx_q > cnt_ext) begin
            // plain schedule: fill the active slot or push
            idx_d = (op_i == OP_SCHED) ? cnt_ext + 1'b1 : cnt_ext;
            if (!act_v_q) begin
              act_v_d = 1'b1;
              act_t_d = handle_i;
            end else if (full) begin
              overflow_o = 1'b1;
            end else begin
              cmd_o.ins = 1'b1;
              cnt_d     = cnt_q + 1'b1;
            end
          end else if (full) begin
            overflow_o = 1'b1;
          end else begin
            // insert at idx, which sits cnt - idx cells below the top
            cmd_o.ins = 1'b1;
            dist_o    = cnt_q - CW'(idx_q);
            cnt_d     = cnt_q + 1'b1;
          end
        end
        OP_NEXT: begin
          idx_d = cnt_ext + 1'b1;
          if (act_v_q) begin
            next_thread_o = act_t_q;
            next_valid_o  = 1'b1;
            act_v_d       = 1'b0;
          end else if (cnt_q != '0) begin
            next_thread_o = top_i;
            next_valid_o  = 1'b1;
            cmd_o.pop     = 1'b1;
            cnt_d         = cnt_q - 1'b1;
          end
        end
        default: begin
          idx_d   = '0;
          act_v_d = 1'b0;
        end
      endcase
    end
  end

  assign has_work_o = act_v_d || (cnt_d != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_v_q <= 1'b0;
      act_t_q <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else begin
      act_v_q <= act_v_d;
      act_t_q <= act_t_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/backtrack_thread_stack_scheduler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// backtrack_thread_stack_scheduler
// Depth-first thread scheduler: active slot plus a stack of thread handles
// held in a chain of cells, with in-order insertion below the top.
// ----------------------------------------------------------------------------
// the result of an accepted word is registered and shows in the output register in the next cycle
// throughput: one word per cycle unless the result side stalls; every cell shifts in the same cycle
// s_axis_tready stays high while the output register is empty or being taken
// reset clears the active slot, stack count, insert index and output valid;
// stack cells hold no reset value and are never read before written
module backtrack_thread_stack_scheduler
  import btss_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned THREAD_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [HANDLE_BITS-1:0] s_axis_tdata,   // thread_id[15:0]
  input  wire logic [OP_BITS-1:0]     s_axis_tuser,   // op[1:0]
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic      [HANDLE_BITS-1:0] m_axis_tdata,   // next_thread[15:0]
  output logic      [RES_BITS-1:0]    m_axis_tuser    // next_valid, has_work, overflow
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IW = $clog2(STACK_DEPTH + 2);
  localparam int unsigned TW = THREAD_BITS;

  logic          accept;
  logic [31:0]   in_wide;
  logic [TW-1:0] handle;
  btss_cmd_t     cmd;
  logic [CW-1:0] ins_dist;
  logic [TW-1:0] res_thread;
  logic [31:0]   res_wide;
  logic          res_nv, res_hw, res_ovf;
  logic [TW-1:0] cell_data [STACK_DEPTH];

  logic                   out_v_q;
  logic [HANDLE_BITS-1:0] out_data_q;
  logic [RES_BITS-1:0]    out_user_q;

  assign s_axis_tready = !out_v_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign in_wide = 32'(s_axis_tdata);
  assign handle  = in_wide[TW-1:0];

  btss_ctrl #(
    .DEPTH (STACK_DEPTH),
    .CW    (CW),
    .IW    (IW),
    .TW    (TW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .op_i          (s_axis_tuser),
    .handle_i      (handle),
    .top_i         (cell_data[0]),
    .cmd_o         (cmd),
    .dist_o        (ins_dist),
    .next_thread_o (res_thread),
    .next_valid_o  (res_nv),
    .has_work_o    (res_hw),
    .overflow_o    (res_ovf)
  );

  for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
    logic [TW-1:0] upper, lower;
    if (k == 0) begin : g_top
      assign upper = handle;
    end else begin : g_mid
      assign upper = cell_data[k-1];
    end
    if (k == STACK_DEPTH - 1) begin : g_end
      assign lower = '0;
    end else begin : g_inner
      assign lower = cell_data[k+1];
    end
    btss_cell #(
      .IDX (k),
      .DW  (CW),
      .TW  (TW)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .dist_i  (ins_dist),
      .new_i   (handle),
      .upper_i (upper),
      .lower_i (lower),
      .data_o  (cell_data[k])
    );
  end

  assign res_wide = 32'(res_thread);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (accept) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q                <= res_wide[HANDLE_BITS-1:0];
      out_user_q[RES_NV_BIT]    <= res_nv;
      out_user_q[RES_HW_BIT]    <= res_hw;
      out_user_q[RES_OVF_BIT]   <= res_ovf;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule
`default_nettype wire

// ===== hdl/btss_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// btss_checker
// Port-level checks for the backtrack thread stack scheduler.
// ----------------------------------------------------------------------------
module btss_checker
  import btss_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic [HANDLE_BITS-1:0] s_axis_tdata,
  input wire logic [OP_BITS-1:0]     s_axis_tuser,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [HANDLE_BITS-1:0] m_axis_tdata,
  input wire logic [RES_BITS-1:0]    m_axis_tuser
);

  // a stalled result word stays presented
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  // input side never blocks while the output register is empty
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  // no thread handed out means a zero handle
  a_zero_thread: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[RES_NV_BIT] |-> m_axis_tdata == '0)
    else $error("nonzero thread without next_valid");

  // a schedule always leaves work and never hands out a thread
  a_sched_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_SCHED
    |=> m_axis_tvalid && m_axis_tuser[RES_HW_BIT] && !m_axis_tuser[RES_NV_BIT])
    else $error("schedule result without pending work");

  // overflow only comes with pending work and no handed-out thread
  a_ovf_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[RES_OVF_BIT]
    |-> m_axis_tuser[RES_HW_BIT] && !m_axis_tuser[RES_NV_BIT])
    else $error("overflow with inconsistent flags");

endmodule

bind backtrack_thread_stack_scheduler btss_checker u_btss_checker (.*);
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the backtrack thread stack scheduler. A scoreboard
// object keeps its own copy of the active slot, handle stack and insert index,
// predicts the result word of every accepted operation and checks the result
// stream in order. Stimulus is a short directed run followed by random
// segments: stack fills, drains, in-order insert runs, full-stack inserts and
// noise, with random gaps and back-pressure on both streams.
// ----------------------------------------------------------------------------
module tb_top
  import btss_pkg::*;
();

  localparam int unsigned DEPTH       = 64;
  localparam int unsigned TBITS       = 16;
  localparam int unsigned WORD_TARGET = 1170;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [HANDLE_BITS-1:0] thread;
    logic                   nv;
    logic                   hw;
    logic                   ovf;
  } sched_result_t;

  class sched_scoreboard;
    bit                     act_v;
    logic [HANDLE_BITS-1:0] act_t;
    logic [HANDLE_BITS-1:0] stk [DEPTH];
    int unsigned            cnt;
    int unsigned            idx;
    sched_result_t          pending_results [$];
    int unsigned            failures;

    function new();
      act_v    = 1'b0;
      act_t    = '0;
      cnt      = 0;
      idx      = 0;
      failures = 0;
    endfunction

    function bit push_thread(logic [HANDLE_BITS-1:0] h);
      if (cnt >= DEPTH) return 1'b1;
      stk[cnt] = h;
      cnt++;
      return 1'b0;
    endfunction

    function bit insert_thread(int unsigned pos, logic [HANDLE_BITS-1:0] h);
      int unsigned p;
      if (cnt >= DEPTH) return 1'b1;
      p = (pos > cnt) ? cnt : pos;
      for (int unsigned i = cnt; i > p; i--) stk[i] = stk[i-1];
      stk[p] = h;
      cnt++;
      return 1'b0;
    endfunction

    function bit schedule_thread(logic [HANDLE_BITS-1:0] h);
      idx = cnt + 1;
      if (act_v) return push_thread(h);
      act_v = 1'b1;
      act_t = h;
      return 1'b0;
    endfunction

    function void note_input(logic [OP_BITS-1:0] op, logic [HANDLE_BITS-1:0] id);
      sched_result_t          r;
      int unsigned            len;
      logic [HANDLE_BITS-1:0] h;
      r = '0;
      h = id & HANDLE_BITS'((1 << TBITS) - 1);
      case (op)
        OP_SCHED: r.ovf = schedule_thread(h);
        OP_ORDER: begin
          len = cnt;
          if (idx > len) begin
            r.ovf = schedule_thread(h);
            idx   = len;
          end else if (idx == len) begin
            r.ovf = push_thread(h);
          end else begin
            r.ovf = insert_thread(idx, h);
          end
        end
        OP_NEXT: begin
          idx = cnt + 1;
          if (act_v) begin
            r.thread = act_t;
            r.nv     = 1'b1;
            act_v    = 1'b0;
          end else if (cnt > 0) begin
            cnt--;
            r.thread = stk[cnt];
            r.nv     = 1'b1;
          end
        end
        default: begin
          idx   = 0;
          act_v = 1'b0;
        end
      endcase
      r.hw = act_v || (cnt > 0);
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [HANDLE_BITS-1:0] data, logic [RES_BITS-1:0] user);
      sched_result_t e;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected result word: thread %h flags %b", data, user);
        return;
      end
      e = pending_results.pop_front();
      if (data !== e.thread || user[RES_NV_BIT] !== e.nv ||
          user[RES_HW_BIT] !== e.hw || user[RES_OVF_BIT] !== e.ovf) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display({"mismatch: thread exp %h got %h, nv exp %b got %b, ",
                    "hw exp %b got %b, ovf exp %b got %b"},
                   e.thread, data, e.nv, user[RES_NV_BIT], e.hw, user[RES_HW_BIT],
                   e.ovf, user[RES_OVF_BIT]);
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [HANDLE_BITS-1:0] s_axis_tdata;   // thread_id[15:0]
  logic [OP_BITS-1:0]     s_axis_tuser;   // op[1:0]
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [HANDLE_BITS-1:0] m_axis_tdata;   // next_thread[15:0]
  logic [RES_BITS-1:0]    m_axis_tuser;   // next_valid, has_work, overflow

  sched_scoreboard sb;
  int unsigned     words_sent;
  int unsigned     cycle_count;
  bit              no_gaps;

  backtrack_thread_stack_scheduler #(
    .STACK_DEPTH (DEPTH),
    .THREAD_BITS (TBITS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [HANDLE_BITS-1:0] rand_handle();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return HANDLE_BITS'($urandom_range(0, 65535));
  endfunction

  task automatic send_word(input logic [OP_BITS-1:0] op, input logic [HANDLE_BITS-1:0] id);
    int unsigned gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= id;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(op, id);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic run_segment();
    int unsigned n;
    no_gaps = ($urandom_range(0, 5) == 0);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        // fill the stack, mostly past full
        n = $urandom_range(60, 72);
        repeat (n)
          send_word(($urandom_range(0, 3) == 0) ? OP_ORDER : OP_SCHED, rand_handle());
      end
      3, 4: begin
        n = $urandom_range(20, 70);
        repeat (n)
          send_word(($urandom_range(0, 7) == 0) ? OP_SCHED : OP_NEXT, rand_handle());
      end
      5, 6: begin
        // in-order inserts below the top after an init
        send_word(OP_INIT, rand_handle());
        n = $urandom_range(3, 15);
        repeat (n)
          send_word(($urandom_range(0, 5) == 0) ? OP_NEXT : OP_ORDER, rand_handle());
      end
      7: begin
        while (sb.cnt < DEPTH) send_word(OP_SCHED, rand_handle());
        send_word(OP_SCHED, rand_handle());
        send_word(OP_INIT, rand_handle());
        send_word(OP_ORDER, rand_handle());
        send_word(OP_ORDER, rand_handle());
        send_word(OP_NEXT, rand_handle());
        send_word(OP_ORDER, rand_handle());
      end
      default: begin
        n = $urandom_range(5, 25);
        repeat (n)
          send_word(OP_BITS'($urandom_range(0, 3)), HANDLE_BITS'($urandom_range(0, 65535)));
      end
    endcase
  endtask

  // result side back-pressure
  initial begin
    int unsigned gap;
    int unsigned run;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    m_axis_tready <= 1'b1;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
      repeat (run) @(negedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    sb            = new();
    words_sent    = 0;
    cycle_count   = 0;
    no_gaps       = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_INIT;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty next, extremes, each in-order insert case
    send_word(OP_NEXT,  16'h0000);
    send_word(OP_SCHED, 16'h0000);
    send_word(OP_SCHED, 16'hFFFF);
    send_word(OP_ORDER, 16'h1234);   // index equals count: plain push
    send_word(OP_NEXT,  16'hFFFF);
    send_word(OP_INIT,  16'hFFFF);
    send_word(OP_ORDER, 16'hA5A5);   // index below count: insert at bottom
    send_word(OP_ORDER, 16'h5A5A);
    send_word(OP_SCHED, 16'h8001);
    send_word(OP_ORDER, 16'h7FFE);   // index above count: acts as schedule
    repeat (7) send_word(OP_NEXT, 16'h0000);
    send_word(OP_INIT,  16'h0000);
    send_word(OP_ORDER, 16'hFFFF);
    send_word(OP_NEXT,  16'h0001);
    send_word(OP_INIT,  16'h0000);

    while (words_sent < WORD_TARGET) run_segment();
    s_axis_tvalid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (sb.failures == 0 && sb.pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
